// ===== rtl/ip2t_pkg.sv =====
// Shared types, codes and character helpers for the address-to-text formatter.
// Used by ip2t_char_unit and ip_address_to_text_core; depends on nothing else.
package ip2t_pkg;

   localparam logic [1:0] FAMILY_V4 = 2'd0;
   localparam logic [1:0] FAMILY_V6 = 2'd1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOSPACE   = 2'd1;
   localparam logic [1:0] STATUS_BADFAMILY = 2'd2;

   localparam logic [7:0] V4_MIN_SPACE = 8'd16;
   localparam logic [7:0] V6_MIN_SPACE = 8'd46;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   // Request to the shared character unit: one element and a digit position.
   typedef struct packed {
      logic        v6;
      logic [15:0] value;
      logic [1:0]  pos;
   } char_req_type;

   // Answer: the character at that position and the first significant position.
   typedef struct packed {
      logic [7:0] ch;
      logic [1:0] first_pos;
   } char_rsp_type;

   // Lower-case hex or decimal digit to ASCII.
   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = 8'h30 + {4'd0, d};
      end else begin
         c = 8'h57 + {4'd0, d};
      end
      return c;
   endfunction

endpackage

// ===== rtl/ip_address_to_text_core.sv =====
// Top level of the address-to-text formatter: sequencer, address store and
// output register around the shared digit unit.
// Depends on ip2t_pkg and ip2t_char_unit.
//
// Usage: one request beat carries an address (req_tdata) and its family
// (req_tuser). The block answers with a stream of response beats, one text
// character each, ending with a zero character flagged by rsp_tlast. A short
// buffer space or an unsupported family gives a single beat with tlast set,
// character zero and a nonzero status in rsp_tuser.
// A request is taken only while the sequencer is idle. Each element (octet or
// group) is first decoded by the shared digit unit in ST_START, then its
// characters are emitted one beat each, followed by a separator or colon beat.
// Unless the address opens with a compressed run, the first character is
// decoded in ST_START and written from ST_DIGIT into the single output
// register. When the receiver stalls, the output register holds its beat and
// the sequencer waits; no beat is lost. Reset returns the sequencer to idle
// and empties the output register; the other registers are not reset.
module ip_address_to_text_core
   import ip2t_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,  // addr_high[63:0], addr_low[127:64], buffer_space[135:128]
   input  logic [1:0]   req_tuser,  // family[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,  // text_char[7:0]
   output logic         rsp_tlast,
   output logic [1:0]   rsp_tuser   // status[1:0]
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_PREFIX,
      ST_COLON,
      ST_DIGIT,
      ST_SEP,
      ST_TERM,
      ST_ERR
   } state_type;

   state_type    state_ff, state_in;
   logic [127:0] addr_ff, addr_in;
   logic         v6_ff, v6_in;
   logic [7:0]   zmask_ff, zmask_in;
   logic [2:0]   idx_ff, idx_in;
   logic [1:0]   pos_ff, pos_in;
   logic [15:0]  cur_ff, cur_in;
   logic         compressed_ff, compressed_in;
   logic [1:0]   err_status_ff, err_status_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   rsp_data_ff, rsp_data_in;
   logic         rsp_last_ff, rsp_last_in;
   logic [1:0]   rsp_status_ff, rsp_status_in;

   logic         req_fire;
   logic         out_free;
   logic [63:0]  in_high;
   logic [63:0]  in_low;
   logic [127:0] in_addr;
   logic [7:0]   in_space;
   logic [15:0]  load_val;
   logic         start_compress;
   logic [3:0]   skip_base;
   logic         skip_found;
   logic [2:0]   skip_idx;
   char_req_type unit_req;
   char_rsp_type unit_rsp;

   assign in_high  = req_tdata[63:0];
   assign in_low   = req_tdata[127:64];
   assign in_addr  = {in_high, in_low};
   assign in_space = req_tdata[135:128];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

   ip2t_char_unit u_char_unit (
      .req (unit_req),
      .rsp (unit_rsp)
   );

   always_comb begin
      // Element for the current index: an IPv6 group or an IPv4 octet.
      if (v6_ff) begin
         load_val = 16'(addr_ff >> {3'd7 - idx_ff, 4'b0000});
      end else begin
         load_val = {8'd0, 8'(addr_ff[31:0] >> {2'd3 - idx_ff[1:0], 3'b000})};
      end

      start_compress = !compressed_ff && (idx_ff <= 3'd5) && zmask_ff[idx_ff] &&
                       zmask_ff[idx_ff + 3'd1] && zmask_ff[idx_ff + 3'd2];

      // First nonzero group at or after the end of the three-group run.
      skip_base  = {1'b0, idx_ff} + 4'd3;
      skip_found = 1'b0;
      skip_idx   = 3'd0;
      for (int g = 7; g >= 0; g--) begin
         if (!zmask_ff[g] && (4'(g) >= skip_base)) begin
            skip_found = 1'b1;
            skip_idx   = 3'(g);
         end
      end

      unit_req.v6    = v6_ff;
      unit_req.value = (state_ff == ST_START) ? load_val : cur_ff;
      unit_req.pos   = pos_ff;
   end

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      v6_in         = v6_ff;
      zmask_in      = zmask_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      cur_in        = cur_ff;
      compressed_in = compressed_ff;
      err_status_in = err_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               addr_in       = in_addr;
               v6_in         = (req_tuser == FAMILY_V6);
               idx_in        = 3'd0;
               compressed_in = 1'b0;
               for (int g = 0; g < 8; g++) begin
                  zmask_in[g] = (in_addr[127 - 16 * g -: 16] == 16'd0);
               end
               if (req_tuser == FAMILY_V4) begin
                  if (in_space < V4_MIN_SPACE) begin
                     err_status_in = STATUS_NOSPACE;
                     state_in      = ST_ERR;
                  end else begin
                     state_in = ST_START;
                  end
               end else if (req_tuser == FAMILY_V6) begin
                  if (in_space < V6_MIN_SPACE) begin
                     err_status_in = STATUS_NOSPACE;
                     state_in      = ST_ERR;
                  end else begin
                     state_in = ST_START;
                  end
               end else begin
                  err_status_in = STATUS_BADFAMILY;
                  state_in      = ST_ERR;
               end
            end
         end
         ST_START: begin
            if (v6_ff && start_compress) begin
               compressed_in = 1'b1;
               state_in      = (idx_ff == 3'd0) ? ST_PREFIX : ST_COLON;
            end else begin
               cur_in   = load_val;
               pos_in   = unit_rsp.first_pos;
               state_in = ST_DIGIT;
            end
         end
         ST_PREFIX: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = CHAR_COLON;
               rsp_last_in   = 1'b0;
               rsp_status_in = STATUS_OK;
               state_in      = ST_COLON;
            end
         end
         ST_COLON: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = CHAR_COLON;
               rsp_last_in   = 1'b0;
               rsp_status_in = STATUS_OK;
               if (skip_found) begin
                  idx_in   = skip_idx;
                  state_in = ST_START;
               end else begin
                  state_in = ST_TERM;
               end
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = unit_rsp.ch;
               rsp_last_in   = 1'b0;
               rsp_status_in = STATUS_OK;
               if (pos_ff != 2'd0) begin
                  pos_in = pos_ff - 2'd1;
               end else if ((v6_ff && idx_ff == 3'd7) || (!v6_ff && idx_ff == 3'd3)) begin
                  state_in = ST_TERM;
               end else begin
                  state_in = ST_SEP;
               end
            end
         end
         ST_SEP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = v6_ff ? CHAR_COLON : CHAR_DOT;
               rsp_last_in   = 1'b0;
               rsp_status_in = STATUS_OK;
               idx_in        = idx_ff + 3'd1;
               state_in      = ST_START;
            end
         end
         ST_TERM: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = CHAR_NUL;
               rsp_last_in   = 1'b1;
               rsp_status_in = STATUS_OK;
               state_in      = ST_IDLE;
            end
         end
         ST_ERR: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = CHAR_NUL;
               rsp_last_in   = 1'b1;
               rsp_status_in = err_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff       <= addr_in;
      v6_ff         <= v6_in;
      zmask_ff      <= zmask_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      cur_ff        <= cur_in;
      compressed_ff <= compressed_in;
      err_status_ff <= err_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   // A taken request always starts work on the next cycle.
   a_req_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("request beat taken but sequencer stayed idle");

   // Error beats are single zero characters closing the item.
   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STATUS_OK) |-> (rsp_tlast && rsp_tdata == CHAR_NUL))
      else $error("error beat without tlast or with a character");

   // Decimal digit positions never exceed hundreds.
   a_v4_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGIT && !v6_ff) |-> pos_ff <= 2'd2)
      else $error("decimal digit position out of range");

   // The double colon is emitted only after compression has been taken.
   a_colon_compressed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COLON || state_ff == ST_PREFIX) |-> (compressed_ff && v6_ff))
      else $error("compression colon without compression");

endmodule

// ===== rtl/ip2t_char_unit.sv =====
// Shared digit unit: turns one IPv4 octet or one IPv6 group into a digit
// character at a given position and finds the first significant digit.
// Depends on ip2t_pkg.
module ip2t_char_unit
   import ip2t_pkg::*;
(
   input  char_req_type req,
   output char_rsp_type rsp
);

   logic [7:0] octet;
   logic [1:0] hund;
   logic [6:0] rem100;
   logic [3:0] tens;
   logic [6:0] ones;
   logic [3:0] dec_digit;
   logic [1:0] dec_first;
   logic [3:0] nibble;
   logic [1:0] hex_first;

   always_comb begin
      octet = req.value[7:0];
      if (octet >= 8'd200) begin
         hund   = 2'd2;
         rem100 = 7'(octet - 8'd200);
      end else if (octet >= 8'd100) begin
         hund   = 2'd1;
         rem100 = 7'(octet - 8'd100);
      end else begin
         hund   = 2'd0;
         rem100 = octet[6:0];
      end
      // Each threshold is an independent compare; their count is the tens digit.
      tens = 4'd0;
      for (int k = 1; k <= 9; k++) begin
         if (rem100 >= 7'(k * 10)) begin
            tens = 4'(k);
         end
      end
      ones = rem100 - 7'({3'd0, tens} * 7'd10);

      case (req.pos)
         2'd2:    dec_digit = {2'd0, hund};
         2'd1:    dec_digit = tens;
         default: dec_digit = ones[3:0];
      endcase

      if (octet >= 8'd100) begin
         dec_first = 2'd2;
      end else if (octet >= 8'd10) begin
         dec_first = 2'd1;
      end else begin
         dec_first = 2'd0;
      end

      nibble = 4'(req.value >> {req.pos, 2'b00});
      if (req.value[15:12] != 4'd0) begin
         hex_first = 2'd3;
      end else if (req.value[11:8] != 4'd0) begin
         hex_first = 2'd2;
      end else if (req.value[7:4] != 4'd0) begin
         hex_first = 2'd1;
      end else begin
         hex_first = 2'd0;
      end

      if (req.v6) begin
         rsp.ch        = digit_char(nibble);
         rsp.first_pos = hex_first;
      end else begin
         rsp.ch        = digit_char(dec_digit);
         rsp.first_pos = dec_first;
      end
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for ip_address_to_text_core: drives address requests, predicts the
// text stream of every accepted request and checks each response beat in order.
// Depends on ip2t_pkg and the formatter RTL.
`timescale 1ns / 1ps

module tb_top;
   import ip2t_pkg::*;

   localparam logic [1:0] FAMILY_RSVD2 = 2'd2;
   localparam logic [1:0] FAMILY_RSVD3 = 2'd3;
   localparam int unsigned STALL_LIMIT = 1000;
   localparam int unsigned DRAIN_CYCLES = 64;
   localparam int unsigned RANDOM_ITEMS = 370;

   typedef struct {
      logic [1:0]  family;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [7:0]  buffer_space;
   } addr_item_type;

   typedef struct {
      logic [7:0] text_char;
      logic       last;
      logic [1:0] status;
   } text_beat_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;  // addr_high[63:0], addr_low[127:64], buffer_space[135:128]
   logic [1:0]   req_tuser = '0;  // family[1:0]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [7:0]   rsp_tdata;       // text_char[7:0]
   logic         rsp_tlast;
   logic [1:0]   rsp_tuser;       // status[1:0]

   addr_item_type pending_addrs[$];
   text_beat_type text_expect[$];
   addr_item_type driven_addr;
   int unsigned   req_beats = 0;
   int unsigned   rsp_beats = 0;
   int unsigned   stall_cycles = 0;
   int unsigned   err_count = 0;

   ip_address_to_text_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   function automatic logic [7:0] digit_ascii(input int unsigned d);
      string digits = "0123456789abcdef";
      return digits[d];
   endfunction

   function automatic void push_text(input logic [7:0] ch, input logic lst,
                                     input logic [1:0] st);
      text_beat_type b;
      b.text_char = ch;
      b.last      = lst;
      b.status    = st;
      text_expect.push_back(b);
   endfunction

   // Appends the full character stream that one request must produce.
   function automatic void format_expected_text(input addr_item_type it);
      logic [15:0] grp [8];
      logic [7:0]  oct;
      logic [3:0]  nib;
      int unsigned i;
      bit          squeezed;
      bit          lead;
      case (it.family)
         FAMILY_V4: begin
            if (it.buffer_space < V4_MIN_SPACE) begin
               push_text(CHAR_NUL, 1'b1, STATUS_NOSPACE);
            end else begin
               for (i = 0; i < 4; i++) begin
                  oct = it.addr_low[31 - 8 * i -: 8];
                  if (oct >= 100) push_text(digit_ascii(oct / 100), 1'b0, STATUS_OK);
                  if (oct >= 10) push_text(digit_ascii((oct / 10) % 10), 1'b0, STATUS_OK);
                  push_text(digit_ascii(oct % 10), 1'b0, STATUS_OK);
                  if (i != 3) push_text(CHAR_DOT, 1'b0, STATUS_OK);
               end
               push_text(CHAR_NUL, 1'b1, STATUS_OK);
            end
         end
         FAMILY_V6: begin
            if (it.buffer_space < V6_MIN_SPACE) begin
               push_text(CHAR_NUL, 1'b1, STATUS_NOSPACE);
            end else begin
               for (i = 0; i < 8; i++) begin
                  grp[i] = (i < 4) ? it.addr_high[63 - 16 * i -: 16]
                                   : it.addr_low[63 - 16 * (i - 4) -: 16];
               end
               i = 0;
               squeezed = 1'b0;
               while (i < 8) begin
                  // Only the first run of three zero groups starting at 0..5 is squeezed.
                  if (!squeezed && i <= 5 && grp[i] == 16'd0 && grp[i + 1] == 16'd0 &&
                      grp[i + 2] == 16'd0) begin
                     squeezed = 1'b1;
                     if (i == 0) push_text(CHAR_COLON, 1'b0, STATUS_OK);
                     push_text(CHAR_COLON, 1'b0, STATUS_OK);
                     i += 3;
                     while (i < 8 && grp[i] == 16'd0) i++;
                  end
                  if (i < 8) begin
                     lead = 1'b0;
                     for (int s = 3; s > 0; s--) begin
                        nib = grp[i][4 * s +: 4];
                        if (lead || nib != 4'd0) begin
                           push_text(digit_ascii(nib), 1'b0, STATUS_OK);
                           lead = 1'b1;
                        end
                     end
                     push_text(digit_ascii(grp[i][3:0]), 1'b0, STATUS_OK);
                     if (i != 7) push_text(CHAR_COLON, 1'b0, STATUS_OK);
                     i++;
                  end
               end
               push_text(CHAR_NUL, 1'b1, STATUS_OK);
            end
         end
         default: begin
            push_text(CHAR_NUL, 1'b1, STATUS_BADFAMILY);
         end
      endcase
   endfunction

   task automatic add_addr(input logic [1:0] fam, input logic [63:0] hi,
                           input logic [63:0] lo, input logic [7:0] sp);
      addr_item_type it;
      it.family       = fam;
      it.addr_high    = hi;
      it.addr_low     = lo;
      it.buffer_space = sp;
      pending_addrs.push_back(it);
   endtask

   function automatic logic [7:0] random_octet();
      case ($urandom_range(3))
         0:       return 8'($urandom_range(9));
         1:       return 8'($urandom_range(99, 10));
         2:       return 8'($urandom_range(255, 100));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Zero groups are frequent so that runs of every length and position occur.
   function automatic logic [15:0] random_group();
      case ($urandom_range(9))
         0, 1, 2, 3: return 16'd0;
         4:          return 16'($urandom_range(15, 1));
         5:          return 16'($urandom_range(255, 16));
         6:          return 16'($urandom_range(4095, 256));
         default:    return 16'($urandom);
      endcase
   endfunction

   // Request driver.
   always @(posedge clock) begin
      addr_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            format_expected_text(driven_addr);
            req_beats++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_addrs.size() > 0 &&
                ((req_beats >= 150 && req_beats < 230) || $urandom_range(99) >= 6)) begin
               it = pending_addrs.pop_front();
               driven_addr = it;
               req_tvalid <= 1'b1;
               req_tdata  <= {it.buffer_space, it.addr_low, it.addr_high};
               req_tuser  <= it.family;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response side back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (rsp_beats >= 2000 && rsp_beats < 3500) || $urandom_range(99) >= 6;
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      text_beat_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_beats++;
         if (text_expect.size() == 0) begin
            $error("unexpected beat: text_char %02h last %0d status %0d",
                   rsp_tdata, rsp_tlast, rsp_tuser);
            err_count++;
         end else begin
            e = text_expect.pop_front();
            if (rsp_tdata !== e.text_char) begin
               $error("text_char: expected %02h, actual %02h", e.text_char, rsp_tdata);
               err_count++;
            end
            if (rsp_tlast !== e.last) begin
               $error("last: expected %0d, actual %0d", e.last, rsp_tlast);
               err_count++;
            end
            if (rsp_tuser !== e.status) begin
               $error("status: expected %0d, actual %0d", e.status, rsp_tuser);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("ip_address_to_text_core: mismatch");
         $finish;
      end
   end

   initial begin
      int unsigned r;
      logic [63:0] hi;
      logic [63:0] lo;

      // Directed cases.
      add_addr(FAMILY_V4, '1, 64'hFFFF_FFFF_0000_0000, 8'd16);
      add_addr(FAMILY_V4, 64'd0, 64'h0000_0000_FFFF_FFFF, 8'd255);
      add_addr(FAMILY_V4, 64'd0, 64'h0000_0000_010A_6409, 8'd200);
      add_addr(FAMILY_V4, 64'd0, 64'hDEAD_BEEF_C0A8_0001, 8'd17);
      add_addr(FAMILY_V4, 64'd0, 64'h0000_0000_0102_0304, 8'd15);
      add_addr(FAMILY_V4, '1, '1, 8'd0);
      add_addr(FAMILY_V6, 64'd0, 64'd0, 8'd46);
      add_addr(FAMILY_V6, '1, '1, 8'd255);
      add_addr(FAMILY_V6, '1, '1, 8'd45);
      add_addr(FAMILY_V6, 64'd0, 64'd0, 8'd0);
      add_addr(FAMILY_V6, 64'd0, 64'h0000_0000_0000_0001, 8'd100);
      add_addr(FAMILY_V6, 64'h2001_0DB8_0000_0000, 64'd0, 8'd46);
      add_addr(FAMILY_V6, 64'h0001_0002_0003_0004, 64'h0005_0000_0000_0000, 8'd80);
      add_addr(FAMILY_V6, 64'h0001_0000_0000_0002, 64'h0003_0004_0005_0006, 8'd80);
      add_addr(FAMILY_V6, 64'h0000_0000_0000_0001, 64'd0, 8'd80);
      add_addr(FAMILY_V6, 64'h0001_0000_0000_0000, 64'h0000_0000_0000_0001, 8'd80);
      add_addr(FAMILY_V6, 64'hFE80_0000_0000_0000, 64'h0202_B3FF_FE1E_8329, 8'd64);
      add_addr(FAMILY_V6, 64'h0ABC_00F0_000F_1000, 64'hFEDC_0000_0000_0000, 8'd64);
      add_addr(FAMILY_V6, 64'h0001_0002_0003_0004, 64'h0005_0006_0000_0000, 8'd64);
      add_addr(FAMILY_RSVD2, '1, '1, 8'd255);
      add_addr(FAMILY_RSVD3, 64'd0, 64'd0, 8'd0);

      // Random part: mostly well-formed requests, some near the space limits.
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         r = $urandom_range(99);
         if (r < 40) begin
            lo = {$urandom, random_octet(), random_octet(), random_octet(), random_octet()};
            add_addr(FAMILY_V4, {$urandom, $urandom}, lo,
                     8'($urandom_range(255, V4_MIN_SPACE)));
         end else if (r < 85) begin
            hi = {random_group(), random_group(), random_group(), random_group()};
            lo = {random_group(), random_group(), random_group(), random_group()};
            add_addr(FAMILY_V6, hi, lo, 8'($urandom_range(255, V6_MIN_SPACE)));
         end else if (r < 93) begin
            add_addr($urandom_range(1) ? FAMILY_V6 : FAMILY_V4, {$urandom, $urandom},
                     {$urandom, $urandom}, 8'($urandom_range(60)));
         end else begin
            add_addr($urandom_range(1) ? FAMILY_RSVD3 : FAMILY_RSVD2, {$urandom, $urandom},
                     {$urandom, $urandom}, 8'($urandom));
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_addrs.size() > 0 || req_tvalid || text_expect.size() > 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (err_count == 0 && text_expect.size() == 0) begin
         $display("ip_address_to_text_core: match");
      end else begin
         $display("ip_address_to_text_core: mismatch");
      end
      $finish;
   end

endmodule
